FILE: src/i2c_eeprom_byte_master_defines.svh
// Assertion macros for the I2C EEPROM byte master.
// No dependencies; included by the top level only.
`ifndef I2C_EEPROM_BYTE_MASTER_DEFINES_SVH
`define I2C_EEPROM_BYTE_MASTER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EBM_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EBM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/i2c_ebm_pkg.sv
// Shared types and constants of the I2C EEPROM byte master.
// No dependencies; used by i2c_ebm_step and the top level.
`timescale 1ns / 1ps
`default_nettype none

package i2c_ebm_pkg;

    // Sequencer phases, one-hot.
    typedef enum logic [19:0] {
        PH_IDLE = 20'b0000_0000_0000_0000_0001,
        PH_S1   = 20'b0000_0000_0000_0000_0010,
        PH_S2   = 20'b0000_0000_0000_0000_0100,
        PH_S3   = 20'b0000_0000_0000_0000_1000,
        PH_WSET = 20'b0000_0000_0000_0001_0000,
        PH_WHI  = 20'b0000_0000_0000_0010_0000,
        PH_WLO  = 20'b0000_0000_0000_0100_0000,
        PH_WREL = 20'b0000_0000_0000_1000_0000,
        PH_AHI  = 20'b0000_0000_0001_0000_0000,
        PH_ALO  = 20'b0000_0000_0010_0000_0000,
        PH_RLO  = 20'b0000_0000_0100_0000_0000,
        PH_RREL = 20'b0000_0000_1000_0000_0000,
        PH_RHI  = 20'b0000_0001_0000_0000_0000,
        PH_RLOW = 20'b0000_0010_0000_0000_0000,
        PH_N1   = 20'b0000_0100_0000_0000_0000,
        PH_N2   = 20'b0000_1000_0000_0000_0000,
        PH_N3   = 20'b0001_0000_0000_0000_0000,
        PH_P1   = 20'b0010_0000_0000_0000_0000,
        PH_P2   = 20'b0100_0000_0000_0000_0000,
        PH_P3   = 20'b1000_0000_0000_0000_0000
    } phase_t;

    // Segments of a command program.
    typedef enum logic [3:0] {
        SEG_START = 4'd0,
        SEG_WDEV  = 4'd1,
        SEG_WADDR = 4'd2,
        SEG_WDATA = 4'd3,
        SEG_RDEV  = 4'd4,
        SEG_ACK   = 4'd5,
        SEG_RBYTE = 4'd6,
        SEG_NOACK = 4'd7,
        SEG_STOP  = 4'd8,
        SEG_END   = 4'd9
    } seg_t;

    // Command codes carried in the input tuser.
    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // Configuration register indexes.
    localparam logic CFG_DEV_WRITE = 1'b0;
    localparam logic CFG_DEV_READ  = 1'b1;

    localparam logic [7:0] DEV_WRITE_RESET = 8'd160;
    localparam logic [7:0] DEV_READ_RESET  = 8'd161;

    localparam seg_t PROG_WRITE [16] = '{
        SEG_START, SEG_WDEV, SEG_ACK, SEG_WADDR, SEG_ACK, SEG_WDATA, SEG_ACK,
        SEG_STOP, SEG_END, SEG_END, SEG_END, SEG_END, SEG_END, SEG_END, SEG_END,
        SEG_END
    };
    localparam seg_t PROG_READ [16] = '{
        SEG_START, SEG_WDEV, SEG_ACK, SEG_WADDR, SEG_ACK, SEG_START, SEG_RDEV,
        SEG_ACK, SEG_RBYTE, SEG_NOACK, SEG_STOP, SEG_END, SEG_END, SEG_END,
        SEG_END, SEG_END
    };

    // Sequencer state, apart from the acknowledge wait counter.
    typedef struct packed {
        phase_t     phase;
        logic [2:0] bit_idx;
        logic [7:0] shift_byte;
        logic       is_read;
        logic [7:0] held_addr;
        logic [7:0] held_data;
        logic       scl;
        logic       sda;
        logic [3:0] step_no;
    } seq_state_t;

    // Status produced with each tick.
    typedef struct packed {
        logic       busy;
        logic       read_valid;
        logic [7:0] read_byte;
    } tick_status_t;

endpackage

`default_nettype wire

FILE: src/i2c_ebm_step.sv
// One-tick sequencer step of the I2C EEPROM byte master (combinational).
// Depends on i2c_ebm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2c_ebm_step #(
    parameter int ACK_WAIT_LIMIT = 200,
    parameter int AW             = 8
) (
    input  var i2c_ebm_pkg::seq_state_t   cur_state,
    input  var logic [AW-1:0]             cur_ack_cnt,
    input  var logic [1:0]                action,
    input  var logic [7:0]                word_addr,
    input  var logic [7:0]                write_data,
    input  var logic                      sda_in,
    input  var logic [7:0]                dev_write_code,
    input  var logic [7:0]                dev_read_code,
    output i2c_ebm_pkg::seq_state_t       next_state,
    output logic [AW-1:0]                 next_ack_cnt,
    output i2c_ebm_pkg::tick_status_t     status
);

    // Load the segment at st.step_no into the state.
    function automatic i2c_ebm_pkg::seq_state_t enter_seg(
        input i2c_ebm_pkg::seq_state_t s,
        input logic [7:0]              wr_code,
        input logic [7:0]              rd_code
    );
        i2c_ebm_pkg::seq_state_t r;
        i2c_ebm_pkg::seg_t       seg;
        r   = s;
        seg = s.is_read ? i2c_ebm_pkg::PROG_READ[s.step_no]
                        : i2c_ebm_pkg::PROG_WRITE[s.step_no];
        r.bit_idx = 3'd0;
        unique case (seg)
            i2c_ebm_pkg::SEG_START: r.phase = i2c_ebm_pkg::PH_S1;
            i2c_ebm_pkg::SEG_WDEV: begin
                r.shift_byte = wr_code;
                r.phase      = i2c_ebm_pkg::PH_WSET;
            end
            i2c_ebm_pkg::SEG_WADDR: begin
                r.shift_byte = s.held_addr;
                r.phase      = i2c_ebm_pkg::PH_WSET;
            end
            i2c_ebm_pkg::SEG_WDATA: begin
                r.shift_byte = s.held_data;
                r.phase      = i2c_ebm_pkg::PH_WSET;
            end
            i2c_ebm_pkg::SEG_RDEV: begin
                r.shift_byte = rd_code;
                r.phase      = i2c_ebm_pkg::PH_WSET;
            end
            i2c_ebm_pkg::SEG_ACK:   r.phase = i2c_ebm_pkg::PH_AHI;
            i2c_ebm_pkg::SEG_RBYTE: begin
                r.shift_byte = 8'd0;
                r.phase      = i2c_ebm_pkg::PH_RLO;
            end
            i2c_ebm_pkg::SEG_NOACK: r.phase = i2c_ebm_pkg::PH_N1;
            i2c_ebm_pkg::SEG_STOP:  r.phase = i2c_ebm_pkg::PH_P1;
            default:                r.phase = i2c_ebm_pkg::PH_IDLE;
        endcase
        return r;
    endfunction

    i2c_ebm_pkg::seq_state_t st;
    logic [AW-1:0]           ack;
    logic                    seg_done;
    logic                    is_cmd;

    assign is_cmd = (action == i2c_ebm_pkg::ACT_WRITE) || (action == i2c_ebm_pkg::ACT_READ);

    always_comb begin
        st       = cur_state;
        ack      = cur_ack_cnt;
        seg_done = 1'b0;
        status   = '0;

        // A command only starts from idle; otherwise it is ignored.
        if (st.phase == i2c_ebm_pkg::PH_IDLE && is_cmd) begin
            st.held_addr = word_addr;
            st.held_data = write_data;
            st.is_read   = (action == i2c_ebm_pkg::ACT_READ);
            st.step_no   = 4'd0;
            st           = enter_seg(st, dev_write_code, dev_read_code);
        end

        if (st.phase != i2c_ebm_pkg::PH_IDLE) begin
            status.busy = 1'b1;
        end

        unique case (st.phase)
            i2c_ebm_pkg::PH_IDLE: ;
            i2c_ebm_pkg::PH_S1: begin st.sda = 1'b1; st.phase = i2c_ebm_pkg::PH_S2; end
            i2c_ebm_pkg::PH_S2: begin st.scl = 1'b1; st.phase = i2c_ebm_pkg::PH_S3; end
            i2c_ebm_pkg::PH_S3: begin st.sda = 1'b0; seg_done = 1'b1; end
            i2c_ebm_pkg::PH_WSET: begin
                st.scl        = 1'b0;
                st.sda        = st.shift_byte[7];
                st.shift_byte = {st.shift_byte[6:0], 1'b0};
                st.phase      = i2c_ebm_pkg::PH_WHI;
            end
            i2c_ebm_pkg::PH_WHI: begin st.scl = 1'b1; st.phase = i2c_ebm_pkg::PH_WLO; end
            i2c_ebm_pkg::PH_WLO: begin
                st.scl = 1'b0;
                if (st.bit_idx == 3'd7) begin
                    st.phase = i2c_ebm_pkg::PH_WREL;
                end else begin
                    st.bit_idx = st.bit_idx + 3'd1;
                    st.phase   = i2c_ebm_pkg::PH_WSET;
                end
            end
            i2c_ebm_pkg::PH_WREL: begin st.sda = 1'b1; seg_done = 1'b1; end
            i2c_ebm_pkg::PH_AHI: begin
                // SCL stays high until the device pulls SDA low or we give up.
                st.scl = 1'b1;
                if (!sda_in || ack >= AW'(ACK_WAIT_LIMIT)) begin
                    st.phase = i2c_ebm_pkg::PH_ALO;
                end else begin
                    ack = ack + AW'(1);
                end
            end
            i2c_ebm_pkg::PH_ALO:  begin st.scl = 1'b0; seg_done = 1'b1; end
            i2c_ebm_pkg::PH_RLO:  begin st.scl = 1'b0; st.phase = i2c_ebm_pkg::PH_RREL; end
            i2c_ebm_pkg::PH_RREL: begin st.sda = 1'b1; st.phase = i2c_ebm_pkg::PH_RHI; end
            i2c_ebm_pkg::PH_RHI: begin
                st.scl        = 1'b1;
                st.shift_byte = {st.shift_byte[6:0], sda_in};
                st.phase      = i2c_ebm_pkg::PH_RLOW;
            end
            i2c_ebm_pkg::PH_RLOW: begin
                st.scl = 1'b0;
                if (st.bit_idx == 3'd7) begin
                    seg_done = 1'b1;
                end else begin
                    st.bit_idx = st.bit_idx + 3'd1;
                    st.phase   = i2c_ebm_pkg::PH_RHI;
                end
            end
            i2c_ebm_pkg::PH_N1: begin st.sda = 1'b1; st.phase = i2c_ebm_pkg::PH_N2; end
            i2c_ebm_pkg::PH_N2: begin st.scl = 1'b1; st.phase = i2c_ebm_pkg::PH_N3; end
            i2c_ebm_pkg::PH_N3: begin st.scl = 1'b0; seg_done = 1'b1; end
            i2c_ebm_pkg::PH_P1: begin st.sda = 1'b0; st.phase = i2c_ebm_pkg::PH_P2; end
            i2c_ebm_pkg::PH_P2: begin st.scl = 1'b1; st.phase = i2c_ebm_pkg::PH_P3; end
            i2c_ebm_pkg::PH_P3: begin st.sda = 1'b1; seg_done = 1'b1; end
            default: st.phase = i2c_ebm_pkg::PH_IDLE;
        endcase

        if (seg_done) begin
            st.step_no = st.step_no + 4'd1;
            st         = enter_seg(st, dev_write_code, dev_read_code);
            // The acknowledge counter starts from zero for every acknowledge.
            if (st.phase == i2c_ebm_pkg::PH_AHI) begin
                ack = '0;
            end
            if (st.phase == i2c_ebm_pkg::PH_IDLE && st.is_read) begin
                status.read_valid = 1'b1;
                status.read_byte  = st.shift_byte;
            end
        end

        next_state   = st;
        next_ack_cnt = ack;
    end

endmodule

`default_nettype wire

FILE: src/i2c_eeprom_byte_master.sv
// I2C EEPROM byte master: an accepted word's result word appears in the next cycle.
// Throughput: one word per cycle unless m_tready stalls the output; each word is one
// bus tick, run through a single combinational step between state and output regs.
// Reset (aresetn, synchronous, active low): sequencer idle, SCL and SDA released high,
// device codes back to 160 (write) and 161 (read), output register empty.
// Depends on i2c_ebm_pkg, i2c_ebm_step and i2c_eeprom_byte_master_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_eeprom_byte_master_defines.svh"

module i2c_eeprom_byte_master #(
    parameter int ACK_WAIT_LIMIT = 200
) (
    input  var logic        aclk,
    input  var logic        aresetn,

    // Configuration write port: index 0 device write code, index 1 device read code.
    input  var logic        cfg_wr_en,
    input  var logic        cfg_addr,
    input  var logic [7:0]  cfg_wdata,

    input  var logic        s_tvalid,
    output logic            s_tready,
    // s_tdata: [7:0] word_addr, [15:8] write_data, [16] sda_in, [23:17] zero.
    input  var logic [23:0] s_tdata,
    // s_tuser: [1:0] action.
    input  var logic [1:0]  s_tuser,

    output logic            m_tvalid,
    input  var logic        m_tready,
    // m_tdata: [0] scl_level, [1] sda_level, [2] busy_res, [10:3] read_byte, [15:11] zero.
    output logic [15:0]     m_tdata,
    // m_tuser: [0] read_valid.
    output logic            m_tuser
);

    // The acknowledge counter only has to reach the wait limit.
    localparam int AW = $clog2(ACK_WAIT_LIMIT + 1);

    // Device control bytes written through the configuration port.
    logic [7:0] dev_wr_reg;
    logic [7:0] dev_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dev_wr_reg <= i2c_ebm_pkg::DEV_WRITE_RESET;
            dev_rd_reg <= i2c_ebm_pkg::DEV_READ_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                i2c_ebm_pkg::CFG_DEV_WRITE: dev_wr_reg <= cfg_wdata;
                i2c_ebm_pkg::CFG_DEV_READ:  dev_rd_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Sequencer state. It only moves when an input word is accepted, since
    // every word is one bus tick.
    i2c_ebm_pkg::seq_state_t   state_reg;
    i2c_ebm_pkg::seq_state_t   state_next;
    logic [AW-1:0]             ack_cnt_reg;
    logic [AW-1:0]             ack_cnt_next;
    i2c_ebm_pkg::tick_status_t status;
    logic                      in_accept;

    // The output register parts the two sides: a new word is taken whenever
    // the register is empty or its word leaves in this same cycle.
    assign s_tready  = !m_tvalid || m_tready;
    assign in_accept = s_tvalid && s_tready;

    i2c_ebm_step #(
        .ACK_WAIT_LIMIT (ACK_WAIT_LIMIT),
        .AW             (AW)
    ) u_step (
        .cur_state      (state_reg),
        .cur_ack_cnt    (ack_cnt_reg),
        .action         (s_tuser),
        .word_addr      (s_tdata[7:0]),
        .write_data     (s_tdata[15:8]),
        .sda_in         (s_tdata[16]),
        .dev_write_code (dev_wr_reg),
        .dev_read_code  (dev_rd_reg),
        .next_state     (state_next),
        .next_ack_cnt   (ack_cnt_next),
        .status         (status)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase      <= i2c_ebm_pkg::PH_IDLE;
            state_reg.bit_idx    <= 3'd0;
            state_reg.shift_byte <= 8'd0;
            state_reg.is_read    <= 1'b0;
            state_reg.held_addr  <= 8'd0;
            state_reg.held_data  <= 8'd0;
            state_reg.scl        <= 1'b1;
            state_reg.sda        <= 1'b1;
            state_reg.step_no    <= 4'd0;
            ack_cnt_reg          <= '0;
        end else if (in_accept) begin
            state_reg   <= state_next;
            ack_cnt_reg <= ack_cnt_next;
        end
    end

    // Result register: pin levels after the tick plus the tick's status.
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic        m_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            m_data_reg <= {5'd0, status.read_byte, status.busy,
                           state_next.sda, state_next.scl};
            m_user_reg <= status.read_valid;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    // A finished read is always reported on a busy tick.
    `EBM_ASSERT_NOW(a_valid_busy, aclk, aresetn, m_tvalid && m_tuser, m_tdata[2],
        "read_valid without busy_res")

    // The acknowledge counter never runs past the wait limit.
    `EBM_ASSERT_NOW(a_ack_limit, aclk, aresetn, 1'b1, ack_cnt_reg <= AW'(ACK_WAIT_LIMIT),
        "acknowledge wait counter beyond limit")

    // A command taken while idle starts a busy sequence on that very tick.
    `EBM_ASSERT_NEXT(a_cmd_starts, aclk, aresetn,
        in_accept && state_reg.phase == i2c_ebm_pkg::PH_IDLE &&
        (s_tuser == i2c_ebm_pkg::ACT_WRITE || s_tuser == i2c_ebm_pkg::ACT_READ),
        m_tvalid && m_tdata[2] && state_reg.phase != i2c_ebm_pkg::PH_IDLE,
        "command accepted in idle did not start a sequence")

    // The sequencer only moves on an accepted word.
    `EBM_ASSERT_NEXT(a_hold_state, aclk, aresetn, !in_accept,
        $stable(state_reg) && $stable(ack_cnt_reg),
        "sequencer state moved without an input word")

endmodule

`default_nettype wire
